// ===== src/rtffc_pkg.sv =====
// Package for the region table carver: command, status and kind codes,
// controller/datapath handshake structs and the firmware kind mapping.
// No dependencies.
package rtffc_pkg;

	localparam int ADDR_W = 49;
	localparam int BASE_W = 48;
	localparam int VA_W   = 64;
	localparam int USED_W = 7;

	localparam logic [ADDR_W-1:0] ADDR_MAX        = {ADDR_W{1'b1}};
	localparam logic [ADDR_W-1:0] ZERO_BASE_SUBST = 49'h2000;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_LOAD    = 2'd1,
		CMD_RESERVE = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RES_OK    = 2'd0,
		RES_FULL  = 2'd1,
		RES_NOFIT = 2'd2
	} res_status_t;

	typedef enum logic [2:0] {
		KIND_USABLE     = 3'd0,
		KIND_ACPI_TABLE = 3'd2,
		KIND_ACPI_NVS   = 3'd3,
		KIND_RESERVED   = 3'd4,
		KIND_ALLOCATED  = 3'd5
	} kind_t;

	// firmware map type codes
	localparam logic [2:0] FW_USABLE      = 3'd0;
	localparam logic [2:0] FW_ACPI_RECLM  = 3'd2;
	localparam logic [2:0] FW_ACPI_NVS    = 3'd3;
	localparam logic [2:0] FW_ALLOC_A     = 3'd5;
	localparam logic [2:0] FW_ALLOC_B     = 3'd7;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_ROUND,
		S_SPLIT,
		S_APPEND,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic exec;
		logic scan_start;
		logic scan_run;
		logic take_hit;
		logic scan_miss;
		logic round;
		logic wr_split;
		logic wr_new;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_fire;
		logic is_reserve;
		logic hit;
		logic full;
		logic done;
		logic out_free;
	} dp_stat_t;

	function automatic kind_t map_kind(input logic [2:0] code);
		kind_t k;
		case (code) inside
			FW_USABLE:              k = KIND_USABLE;
			FW_ACPI_RECLM:          k = KIND_ACPI_TABLE;
			FW_ACPI_NVS:            k = KIND_ACPI_NVS;
			FW_ALLOC_A, FW_ALLOC_B: k = KIND_ALLOCATED;
			default:                k = KIND_RESERVED;
		endcase
		return k;
	endfunction

	function automatic logic kind_raises(input kind_t k);
		return (k == KIND_USABLE) || (k == KIND_ALLOCATED);
	endfunction

endpackage

// ===== src/rtffc_req_if.sv =====
// Request channel of the region table carver: valid/ready plus command word.
// Depends on rtffc_pkg for field widths.
interface rtffc_req_if import rtffc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic [BASE_W-1:0] entry_base;
	logic [BASE_W-1:0] entry_length;
	logic [2:0]        entry_kind;
	logic [BASE_W-1:0] request_size;

	modport source (output valid, command, entry_base, entry_length, entry_kind,
		request_size, input ready);
	modport sink (input valid, command, entry_base, entry_length, entry_kind,
		request_size, output ready);
endinterface

// ===== src/rtffc_rsp_if.sv =====
// Response channel of the region table carver: valid/ready plus result word.
// Depends on rtffc_pkg for field widths.
interface rtffc_rsp_if import rtffc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [VA_W-1:0]   virtual_address;
	logic [ADDR_W-1:0] top_of_memory;
	logic [USED_W-1:0] regions_used;

	modport source (output valid, status, virtual_address, top_of_memory, regions_used,
		input ready);
	modport sink (input valid, status, virtual_address, top_of_memory, regions_used,
		output ready);
endinterface

// ===== src/rtffc_ctrl.sv =====
// Sequencer of the region table carver: steps the datapath through
// execute, scan, carve and result phases. Depends on rtffc_pkg.
module rtffc_ctrl import rtffc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (stat.in_fire) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = stat.is_reserve ? S_SCAN : S_FINISH;
			end
			S_SCAN: begin
				if (stat.hit) begin
					state_d = stat.full ? S_FINISH : S_ROUND;
				end else if (stat.done) begin
					state_d = S_FINISH;
				end
			end
			S_ROUND:  state_d = S_SPLIT;
			S_SPLIT:  state_d = S_APPEND;
			S_APPEND: state_d = S_FINISH;
			S_FINISH: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.in_ready = 1'b1;
			S_EXEC: begin
				cmd.exec       = 1'b1;
				cmd.scan_start = stat.is_reserve;
			end
			S_SCAN: begin
				cmd.scan_run  = 1'b1;
				cmd.take_hit  = stat.hit;
				cmd.scan_miss = stat.done && !stat.hit;
			end
			S_ROUND:  cmd.round    = 1'b1;
			S_SPLIT:  cmd.wr_split = 1'b1;
			S_APPEND: cmd.wr_new   = 1'b1;
			S_FINISH: cmd.finish   = stat.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== src/rtffc_dp.sv =====
// Datapath of the region table carver: region memories, count and memory
// top, scan pipeline, carve arithmetic and the result register.
// Depends on rtffc_pkg, rtffc_req_if and rtffc_rsp_if.
module rtffc_dp import rtffc_pkg::*; #(
	parameter int TABLE_DEPTH = 64,
	parameter int PAGE_SHIFT  = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [VA_W-1:0] dmb,
	input  ctrl_cmd_t       cmd,
	output dp_stat_t        stat,
	rtffc_req_if.sink       req,
	rtffc_rsp_if.source     rsp
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [CW-1:0] MAX_CNT = CW'(TABLE_DEPTH);
	localparam logic [ADDR_W+1:0] PAGE_MASK = (ADDR_W+2)'((64'd1 << PAGE_SHIFT) - 64'd1);

	// region memories
	logic [ADDR_W-1:0] mem_start [TABLE_DEPTH];
	logic [ADDR_W-1:0] mem_limit [TABLE_DEPTH];
	kind_t             mem_kind  [TABLE_DEPTH];

	// latched request word
	logic [1:0]        cmd_q;
	logic [BASE_W-1:0] base_q, length_q, size_q;
	logic [2:0]        kind_in_q;

	logic [CW-1:0]     count_q;
	logic [ADDR_W-1:0] high_q;

	logic [CW-1:0]     scan_idx_q;
	logic              vld_s1;
	logic [ADDR_W-1:0] rd_start_s1, rd_limit_s1;
	kind_t             rd_kind_s1;
	logic [AW-1:0]     rd_idx_s1;

	logic [AW-1:0]     hit_idx_q;
	logic [ADDR_W-1:0] hit_b_q;
	logic [ADDR_W:0]   sum_q;
	logic [ADDR_W-1:0] carved_q;
	res_status_t       res_status_q;
	logic [VA_W-1:0]   va_q;

	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [VA_W-1:0]   out_va_q;
	logic [ADDR_W-1:0] out_top_q;
	logic [USED_W-1:0] out_used_q;

	logic              in_fire, full, do_load, do_clear, issue, fit, hit, done;
	logic [AW-1:0]     cnt_idx;
	logic [ADDR_W-1:0] load_end, load_begin;
	kind_t             load_kind;
	logic [ADDR_W+1:0] rnd;
	logic [ADDR_W-1:0] carved_d;
	logic              we_start, we_side;
	logic [AW-1:0]     start_addr;
	logic [ADDR_W-1:0] start_wdata, limit_wdata;
	kind_t             kind_wdata;

	always_comb begin
		in_fire    = req.valid && req.ready;
		full       = count_q >= MAX_CNT;
		cnt_idx    = count_q[AW-1:0];
		do_clear   = cmd.exec && (cmd_q == CMD_CLEAR);
		do_load    = cmd.exec && (cmd_q == CMD_LOAD) && !full;
		load_end   = {1'b0, base_q} + {1'b0, length_q};
		load_begin = (base_q == '0) ? ZERO_BASE_SUBST : {1'b0, base_q};
		load_kind  = map_kind(kind_in_q);

		fit  = (rd_kind_s1 == KIND_USABLE) && (rd_start_s1 < rd_limit_s1)
			&& ((rd_limit_s1 - rd_start_s1) >= {1'b0, size_q});
		hit   = vld_s1 && fit;
		issue = cmd.scan_run && (scan_idx_q < count_q);
		done  = !vld_s1 && (scan_idx_q >= count_q);

		// round the carved end up to a page, saturate at the address range
		rnd      = ({1'b0, sum_q} + PAGE_MASK) & ~PAGE_MASK;
		carved_d = (rnd > {2'b00, ADDR_MAX}) ? ADDR_MAX : rnd[ADDR_W-1:0];

		we_start    = do_load || cmd.wr_split || cmd.wr_new;
		start_addr  = cmd.wr_split ? hit_idx_q : cnt_idx;
		start_wdata = do_load ? load_begin : (cmd.wr_split ? carved_q : hit_b_q);
		we_side     = do_load || cmd.wr_new;
		limit_wdata = do_load ? load_end : carved_q;
		kind_wdata  = do_load ? load_kind : KIND_ALLOCATED;
	end

	assign req.ready = cmd.in_ready;

	assign stat.in_fire    = in_fire;
	assign stat.is_reserve = (cmd_q == CMD_RESERVE);
	assign stat.hit        = hit;
	assign stat.full       = full;
	assign stat.done       = done;
	assign stat.out_free   = !out_valid_q || rsp.ready;

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.virtual_address = out_va_q;
	assign rsp.top_of_memory   = out_top_q;
	assign rsp.regions_used    = out_used_q;

	// memories: one write port each, registered read at the scan index
	always_ff @(posedge clk) begin
		if (we_start) mem_start[start_addr] <= start_wdata;
		if (we_side) begin
			mem_limit[cnt_idx] <= limit_wdata;
			mem_kind[cnt_idx]  <= kind_wdata;
		end
		if (issue) begin
			rd_start_s1 <= mem_start[scan_idx_q[AW-1:0]];
			rd_limit_s1 <= mem_limit[scan_idx_q[AW-1:0]];
			rd_kind_s1  <= mem_kind[scan_idx_q[AW-1:0]];
			rd_idx_s1   <= scan_idx_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			high_q      <= '0;
			scan_idx_q  <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_clear) begin
				count_q <= '0;
				high_q  <= '0;
			end else begin
				if (do_load || cmd.wr_new) count_q <= count_q + 1'b1;
				if (do_load && kind_raises(load_kind) && (load_end > high_q)) begin
					high_q <= load_end;
				end
			end

			if (cmd.scan_start) begin
				scan_idx_q <= '0;
			end else if (issue) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			vld_s1 <= issue;

			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q     <= req.command;
			base_q    <= req.entry_base;
			length_q  <= req.entry_length;
			kind_in_q <= req.entry_kind;
			size_q    <= req.request_size;
		end
		if (cmd.exec) begin
			res_status_q <= ((cmd_q == CMD_LOAD) && full) ? RES_FULL : RES_OK;
			va_q         <= '0;
		end
		if (cmd.scan_miss) res_status_q <= RES_NOFIT;
		if (cmd.take_hit) begin
			hit_idx_q    <= rd_idx_s1;
			hit_b_q      <= rd_start_s1;
			sum_q        <= {1'b0, rd_start_s1} + {2'b00, size_q};
			res_status_q <= full ? RES_FULL : RES_OK;
		end
		if (cmd.round) begin
			carved_q <= carved_d;
			va_q     <= VA_W'(hit_b_q) + dmb;
		end
		if (cmd.finish) begin
			out_status_q <= res_status_q;
			out_va_q     <= va_q;
			out_top_q    <= high_q;
			out_used_q   <= USED_W'(count_q);
		end
	end

endmodule

// ===== src/region_table_first_fit_carver.sv =====
// Region table with first-fit carving.
// Channels: req (sink) carries a command word: clear the table, load one
// firmware map entry, or reserve bytes. rsp (source) returns one result word
// per request: status, virtual address, memory top and regions in use.
// The direct-map base is a 64-bit register at APB address 0; pready is
// always high and a write lands on the access cycle.
// Clear, load and no-op commands pass from acceptance through the execute
// and finish states before rsp.valid rises. A reserve that carves steps
// through execute, scan, round, split, append and finish states; the scan
// reads one entry a cycle from the region memory port until the first fit,
// then the carve writes that port twice. A reserve that finds no fit scans
// every entry in use; a fit in a full table carves nothing.
// One request is in work at a time; req.ready is high only between
// requests. The result register lets a new request start while the
// previous result waits; a stalled rsp holds the result and the next one
// waits in its final step until rsp.ready.
// Reset clears the region count, memory top, direct-map base and the
// response valid; the table contents need no clearing.
module region_table_first_fit_carver import rtffc_pkg::*; #(
	parameter int TABLE_DEPTH = 64,
	parameter int PAGE_SHIFT  = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	rtffc_req_if.sink   req,
	rtffc_rsp_if.source rsp
);

	// register index sits above the byte lane bits
	localparam int REG_LSB = 3;
	localparam logic REG_DMB = 1'b0;

	logic [VA_W-1:0] dmb_q;
	ctrl_cmd_t       cmd;
	dp_stat_t        stat;
	logic            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[REG_LSB] == REG_DMB);
	assign prdata = (paddr[REG_LSB] == REG_DMB) ? dmb_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmb_q <= '0;
		end else if (cfg_wr) begin
			dmb_q <= pwdata;
		end
	end

	rtffc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	rtffc_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.PAGE_SHIFT  (PAGE_SHIFT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.dmb    (dmb_q),
		.cmd    (cmd),
		.stat   (stat),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ===== dv/tb_region_table_first_fit_carver.sv =====
// Self-checking bench for the region table carver: a directed script, then random
// map/reserve sessions under several direct-map bases, checked against a shadow table.
// Depends on rtffc_pkg, rtffc_req_if, rtffc_rsp_if and region_table_first_fit_carver.
module tb_region_table_first_fit_carver;
	import rtffc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 64;
	localparam int PAGE_SHIFT  = 12;
	localparam logic [3:0]  REG_DIRECT_MAP_BASE = 4'h0;
	localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;
	localparam logic [47:0] ALL48 = {48{1'b1}};
	localparam int N_SCRIPT = 25;
	localparam int N_PHASES = 5;
	localparam int WORDS_PER_PHASE = 130;

	typedef struct packed {
		cmd_t        cmd;
		logic [47:0] base;
		logic [47:0] length;
		logic [2:0]  kind;
		logic [47:0] size;
	} map_word_t;

	typedef struct packed {
		res_status_t       status;
		logic [63:0]       va;
		logic [ADDR_W-1:0] top;
		logic [6:0]        used;
	} carve_result_t;

	typedef struct packed {
		map_word_t     w;
		logic          typed;
		carve_result_t want;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	rtffc_req_if req();
	rtffc_rsp_if rsp();

	region_table_first_fit_carver #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.PAGE_SHIFT(PAGE_SHIFT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req(req),
		.rsp(rsp)
	);

	// shadow of the region table
	logic [ADDR_W-1:0] shadow_lo [TABLE_DEPTH];
	logic [ADDR_W-1:0] shadow_hi [TABLE_DEPTH];
	kind_t             shadow_kind [TABLE_DEPTH];
	int                used_n = 0;
	logic [ADDR_W-1:0] high_mark = '0;
	logic [63:0]       map_base = '0;

	carve_result_t outcomes_due[$];
	int            mismatch_count = 0;
	int            words_sent = 0;
	int            results_seen = 0;
	bit            idling_on = 1'b1;
	logic [63:0]   base_setting [N_PHASES];

	script_row_t script [N_SCRIPT] = '{
		'{'{CMD_RESERVE, 48'h0, 48'h0, 3'd0, 48'h0}, 1'b1, '{RES_NOFIT, 64'h0, 49'h0, 7'd0}},
		'{'{CMD_NOP, ALL48, ALL48, 3'd7, ALL48}, 1'b1, '{RES_OK, 64'h0, 49'h0, 7'd0}},
		// zero base: begin moves to 0x2000, past the end
		'{'{CMD_LOAD, 48'h0, 48'h1000, 3'd0, 48'h0}, 1'b1, '{RES_OK, 64'h0, 49'h1000, 7'd1}},
		'{'{CMD_RESERVE, 48'h0, 48'h0, 3'd0, 48'h0}, 1'b1,
			'{RES_NOFIT, 64'h0, 49'h1000, 7'd1}},
		'{'{CMD_LOAD, 48'h10_0000, 48'h40_0000, 3'd0, 48'h0}, 1'b0, '0},
		'{'{CMD_LOAD, 48'h80_0000, 48'h1000, 3'd1, 48'h0}, 1'b0, '0},
		'{'{CMD_LOAD, 48'h90_0000, 48'h2000, 3'd2, 48'h0}, 1'b0, '0},
		'{'{CMD_LOAD, 48'hA0_0000, 48'h3000, 3'd3, 48'h0}, 1'b0, '0},
		'{'{CMD_LOAD, 48'hB0_0000, 48'h1000, 3'd4, 48'h0}, 1'b0, '0},
		'{'{CMD_LOAD, 48'h100_0000, 48'h10_0000, 3'd5, 48'h0}, 1'b0, '0},
		'{'{CMD_LOAD, 48'hC0_0000, 48'h1000, 3'd6, 48'h0}, 1'b0, '0},
		'{'{CMD_LOAD, 48'h200_0000, 48'h1000, 3'd7, 48'h0}, 1'b0, '0},
		'{'{CMD_RESERVE, 48'h0, 48'h0, 3'd0, 48'h1234}, 1'b0, '0},
		'{'{CMD_RESERVE, 48'h0, 48'h0, 3'd0, 48'h0}, 1'b0, '0},
		// exact fit of what is left
		'{'{CMD_RESERVE, 48'h0, 48'h0, 3'd0, 48'h3F_E000}, 1'b0, '0},
		'{'{CMD_RESERVE, 48'h0, 48'h0, 3'd0, 48'h1}, 1'b0, '0},
		'{'{CMD_LOAD, ALL48, ALL48, 3'd0, 48'h0}, 1'b0, '0},
		// carved end saturates at the top of the address space
		'{'{CMD_RESERVE, 48'h0, 48'h0, 3'd0, ALL48}, 1'b0, '0},
		'{'{CMD_LOAD, 48'h0, 48'h0, 3'd0, 48'h0}, 1'b0, '0},
		'{'{CMD_RESERVE, 48'h0, 48'h0, 3'd0, ALL48}, 1'b1,
			'{RES_NOFIT, 64'h0, 49'h1_FFFF_FFFF_FFFE, 7'd15}},
		'{'{CMD_CLEAR, ALL48, ALL48, 3'd7, ALL48}, 1'b1, '{RES_OK, 64'h0, 49'h0, 7'd0}},
		'{'{CMD_LOAD, 48'h1000, 48'h8000, 3'd0, 48'h0}, 1'b0, '0},
		'{'{CMD_RESERVE, 48'h0, 48'h0, 3'd0, 48'h8000}, 1'b0, '0},
		'{'{CMD_RESERVE, 48'h0, 48'h0, 3'd0, 48'h0}, 1'b0, '0},
		'{'{CMD_NOP, 48'h0, 48'h0, 3'd0, 48'h0}, 1'b0, '0}
	};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("Mismatches found");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("[%0t] ERROR: %s", $time, msg);
	endtask

	// Apply one word to the shadow table and return what the block must answer.
	function automatic carve_result_t shadow_step(input map_word_t w);
		carve_result_t r;
		logic [ADDR_W-1:0] lo, hi;
		logic [63:0] rounded;
		kind_t k;
		bit raises, hit;
		r = '0;
		r.status = RES_OK;
		case (w.cmd)
			CMD_CLEAR: begin
				used_n = 0;
				high_mark = '0;
			end
			CMD_LOAD: begin
				if (used_n >= TABLE_DEPTH) begin
					r.status = RES_FULL;
				end else begin
					hi = {1'b0, w.base} + {1'b0, w.length};
					lo = (w.base == '0) ? ZERO_BASE_SUBST : {1'b0, w.base};
					raises = 1'b0;
					case (w.kind)
						FW_USABLE: begin
							k = KIND_USABLE;
							raises = 1'b1;
						end
						FW_ACPI_RECLM: k = KIND_ACPI_TABLE;
						FW_ACPI_NVS: k = KIND_ACPI_NVS;
						FW_ALLOC_A, FW_ALLOC_B: begin
							k = KIND_ALLOCATED;
							raises = 1'b1;
						end
						default: k = KIND_RESERVED;
					endcase
					if (raises && hi > high_mark)
						high_mark = hi;
					shadow_lo[used_n] = lo;
					shadow_hi[used_n] = hi;
					shadow_kind[used_n] = k;
					used_n++;
				end
			end
			CMD_RESERVE: begin
				hit = 1'b0;
				for (int i = 0; i < used_n; i++) begin
					if (!hit && shadow_kind[i] == KIND_USABLE && shadow_lo[i] < shadow_hi[i] &&
							shadow_hi[i] - shadow_lo[i] >= {1'b0, w.size}) begin
						hit = 1'b1;
						if (used_n >= TABLE_DEPTH) begin
							r.status = RES_FULL;
						end else begin
							lo = shadow_lo[i];
							rounded = ({15'h0, lo} + {16'h0, w.size} + PAGE_MASK) & ~PAGE_MASK;
							hi = (rounded > {15'h0, ADDR_MAX}) ? ADDR_MAX : rounded[ADDR_W-1:0];
							shadow_lo[i] = hi;
							shadow_lo[used_n] = lo;
							shadow_hi[used_n] = hi;
							shadow_kind[used_n] = KIND_ALLOCATED;
							used_n++;
							r.va = {15'h0, lo} + map_base;
						end
					end
				end
				if (!hit)
					r.status = RES_NOFIT;
			end
			default: ;
		endcase
		r.top = high_mark;
		r.used = used_n[6:0];
		return r;
	endfunction

	function automatic logic [47:0] rand48();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[47:0];
	endfunction

	function automatic map_word_t noise_word();
		map_word_t w;
		w.cmd = cmd_t'($urandom_range(0, 3));
		w.base = rand48();
		w.length = rand48();
		w.kind = 3'($urandom_range(0, 7));
		w.size = rand48();
		return w;
	endfunction

	function automatic map_word_t rand_load();
		map_word_t w;
		w = noise_word();
		w.cmd = CMD_LOAD;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: w.base = w.base & 48'h0000_FFFF_F000;
			8: w.base = '0;
			9: w.base = ALL48;
			default: ;
		endcase
		case ($urandom_range(0, 7))
			0, 1, 2, 3, 4: w.length = 48'($urandom_range(1, 4096)) << PAGE_SHIFT;
			6: w.length = '0;
			7: w.length = 48'($urandom_range(0, 'hFFFF));
			default: ;
		endcase
		if ($urandom_range(0, 1) == 0)
			w.kind = FW_USABLE;
		return w;
	endfunction

	// Size a reserve against a usable region of the shadow table.
	function automatic map_word_t fit_reserve();
		map_word_t w;
		int cand[$];
		int j;
		logic [63:0] room, r;
		w = noise_word();
		w.cmd = CMD_RESERVE;
		for (int i = 0; i < used_n; i++)
			if (shadow_kind[i] == KIND_USABLE && shadow_lo[i] < shadow_hi[i])
				cand.push_back(i);
		if (cand.size() != 0) begin
			j = cand[$urandom_range(0, cand.size() - 1)];
			room = {15'h0, shadow_hi[j] - shadow_lo[j]};
			if (room > {16'h0, ALL48})
				room = {16'h0, ALL48};
			r = {$urandom(), $urandom()};
			case ($urandom_range(0, 7))
				0: w.size = '0;
				1: w.size = room[47:0];
				2: w.size = (room == {16'h0, ALL48}) ? ALL48 : room[47:0] + 48'd1;
				3: begin
					r = r % (room + 64'd1);
					w.size = r[47:0];
				end
				default: begin
					r = r % (room / 64'd16 + 64'd1);
					w.size = r[47:0];
				end
			endcase
		end
		return w;
	endfunction

	task automatic send_word(input map_word_t w, input logic typed, input carve_result_t want);
		carve_result_t predicted;
		int gap;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.command <= w.cmd;
		req.entry_base <= w.base;
		req.entry_length <= w.length;
		req.entry_kind <= w.kind;
		req.request_size <= w.size;
		do @(posedge clk); while (req.ready !== 1'b1);
		predicted = shadow_step(w);
		outcomes_due.push_back(typed ? want : predicted);
		if (w.cmd != CMD_NOP)
			words_sent++;
	endtask

	task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (addr == REG_DIRECT_MAP_BASE)
			map_base = data;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read(input logic [3:0] addr, output logic [63:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (outcomes_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic map_session();
		map_word_t w;
		w = noise_word();
		w.cmd = CMD_CLEAR;
		send_word(w, 1'b0, '0);
		repeat ($urandom_range(2, 8))
			send_word(rand_load(), 1'b0, '0);
		repeat ($urandom_range(3, 12)) begin
			case ($urandom_range(0, 19))
				15, 16: w = rand_load();
				17: begin
					w = noise_word();
					w.cmd = CMD_NOP;
				end
				18: w = noise_word();
				19: begin
					w = noise_word();
					w.cmd = CMD_RESERVE;
				end
				default: w = fit_reserve();
			endcase
			send_word(w, 1'b0, '0);
		end
	endtask

	// Load the table to two short of its depth, then push reserves and loads that can fill it and meet it full.
	task automatic fill_session();
		map_word_t w;
		w = noise_word();
		w.cmd = CMD_CLEAR;
		send_word(w, 1'b0, '0);
		while (used_n < TABLE_DEPTH - 2)
			send_word(rand_load(), 1'b0, '0);
		repeat (4)
			send_word(fit_reserve(), 1'b0, '0);
		send_word(rand_load(), 1'b0, '0);
		w = noise_word();
		w.cmd = CMD_RESERVE;
		w.size = ALL48;
		send_word(w, 1'b0, '0);
	endtask

	task automatic check_outcome();
		carve_result_t want;
		results_seen++;
		if (outcomes_due.size() == 0) begin
			flag_mismatch($sformatf("result %0d arrived with nothing outstanding", results_seen));
		end else begin
			want = outcomes_due.pop_front();
			if (rsp.status !== want.status)
				flag_mismatch($sformatf("result %0d status %0d, want %0d",
					results_seen, rsp.status, want.status));
			if (rsp.virtual_address !== want.va)
				flag_mismatch($sformatf("result %0d virtual_address %h, want %h",
					results_seen, rsp.virtual_address, want.va));
			if (rsp.top_of_memory !== want.top)
				flag_mismatch($sformatf("result %0d top_of_memory %h, want %h",
					results_seen, rsp.top_of_memory, want.top));
			if (rsp.regions_used !== want.used)
				flag_mismatch($sformatf("result %0d regions_used %0d, want %0d",
					results_seen, rsp.regions_used, want.used));
		end
	endtask

	// response side: check each accepted word, stall in short bursts while idling is on
	initial begin
		int stall_left;
		stall_left = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
				check_outcome();
			if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [63:0] readback;
		int phase_end;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req.valid <= 1'b0;
		req.command <= CMD_NOP;
		req.entry_base <= '0;
		req.entry_length <= '0;
		req.entry_kind <= '0;
		req.request_size <= '0;
		base_setting[0] = 64'hFFFF_FFFF_FFFF_FFFF;
		base_setting[1] = 64'h0;
		base_setting[2] = {$urandom(), $urandom()};
		base_setting[3] = 64'hFFFF_8000_0000_0000;
		base_setting[4] = {$urandom(), $urandom()};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_read(REG_DIRECT_MAP_BASE, readback);
		if (readback !== 64'h0)
			flag_mismatch($sformatf("direct_map_base after reset reads %h", readback));
		for (int i = 0; i < N_SCRIPT; i++)
			send_word(script[i].w, script[i].typed, script[i].want);
		req.valid <= 1'b0;

		for (int p = 0; p < N_PHASES; p++) begin
			wait_drained();
			reg_write(REG_DIRECT_MAP_BASE, base_setting[p]);
			reg_read(REG_DIRECT_MAP_BASE, readback);
			if (readback !== base_setting[p])
				flag_mismatch($sformatf("direct_map_base reads %h, wrote %h",
					readback, base_setting[p]));
			// last phase runs without any idling
			idling_on = (p != N_PHASES - 1);
			phase_end = words_sent + WORDS_PER_PHASE;
			while (words_sent < phase_end) begin
				if ($urandom_range(0, 9) == 0)
					fill_session();
				else
					map_session();
			end
			req.valid <= 1'b0;
		end

		wait_drained();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
src/rtffc_pkg.sv
src/rtffc_req_if.sv
src/rtffc_rsp_if.sv
src/rtffc_ctrl.sv
src/rtffc_dp.sv
src/region_table_first_fit_carver.sv
dv/tb_region_table_first_fit_carver.sv
